// ===== src/spq_pkg.sv =====
package spq_pkg;

   localparam int TAG_BITS      = 16;
   localparam int PRIO_BITS     = 3;
   localparam int STATUS_BITS   = 2;
   localparam int OUT_NUM_BITS  = 32;
   localparam int PRIO_LEVELS   = 8;

   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_POP = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [PRIO_BITS-1:0] prio;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } cmd_type;

endpackage

// ===== src/stable_priority_task_queue.sv =====
// A result word is valid in the cycle after its request word is accepted.
// Throughput: one request word per cycle while no result word waits on rsp_tready;
// each add or pop moves the whole sorted cell chain by at most one place.
// Reset: synchronous, active high; empties every cell, zeroes the task counter
// and drops any pending result word.
module stable_priority_task_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int NUMBER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // priority_req[2:0], task_tag[18:3], zero[23:19]
   input  logic        req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_tag[15:0], out_priority[18:16],
                                    // task_number[50:19], has_tasks[51], zero[55:52]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   logic                   accept;
   logic                   full;
   cmd_type                cmd;
   entry_type              new_data;
   logic [PRIO_BITS-1:0]   req_prio;
   logic [NUMBER_BITS-1:0] next_number_ff;
   logic [NUMBER_BITS-1:0] next_number_in;

   logic [QUEUE_DEPTH-1:0] vld;
   logic [QUEUE_DEPTH-1:0] ins_vec;
   entry_type              data_arr [QUEUE_DEPTH];
   logic [NUMBER_BITS-1:0] num_arr  [QUEUE_DEPTH];

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff;
   logic [STATUS_BITS-1:0] status_in;
   entry_type              out_ff;
   entry_type              out_in;
   logic [OUT_NUM_BITS-1:0] out_num_ff;
   logic [OUT_NUM_BITS-1:0] out_num_in;
   logic                   has_tasks_ff;
   logic                   has_tasks_in;

   logic [NUMBER_BITS+OUT_NUM_BITS-1:0] stamp_ext;
   logic [NUMBER_BITS+OUT_NUM_BITS-1:0] head_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = vld[QUEUE_DEPTH-1];

   assign req_prio = req_tdata[PRIO_BITS-1:0];
   always_comb begin
      new_data.tag  = req_tdata[PRIO_BITS+TAG_BITS-1:PRIO_BITS];
      new_data.prio = req_prio;
      if (32'(req_prio) > 32'(PRIO_LEVELS - 1)) begin
         new_data.prio = PRIO_BITS'(PRIO_LEVELS - 1);
      end
   end

   assign cmd.push = accept && (req_tuser == REQ_ADD) && !full;
   assign cmd.pop  = accept && (req_tuser == REQ_POP);

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic                   lv;
         entry_type              ld;
         logic [NUMBER_BITS-1:0] ln;
         logic                   li;
         logic                   rv;
         entry_type              rd;
         logic [NUMBER_BITS-1:0] rn;
         if (gi == 0) begin : g_head
            assign lv = 1'b0;
            assign ld = new_data;
            assign ln = next_number_ff;
            assign li = 1'b0;
         end else begin : g_body
            assign lv = vld[gi-1];
            assign ld = data_arr[gi-1];
            assign ln = num_arr[gi-1];
            assign li = ins_vec[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign rv = 1'b0;
            assign rd = new_data;
            assign rn = next_number_ff;
         end else begin : g_mid
            assign rv = vld[gi+1];
            assign rd = data_arr[gi+1];
            assign rn = num_arr[gi+1];
         end
         spq_cell #(
            .NUMBER_BITS(NUMBER_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .new_data    (new_data),
            .new_number  (next_number_ff),
            .left_valid  (lv),
            .left_data   (ld),
            .left_number (ln),
            .left_ins    (li),
            .right_valid (rv),
            .right_data  (rd),
            .right_number(rn),
            .valid       (vld[gi]),
            .data        (data_arr[gi]),
            .number      (num_arr[gi]),
            .ins         (ins_vec[gi])
         );
      end
   endgenerate

   assign stamp_ext = {{OUT_NUM_BITS{1'b0}}, next_number_ff};
   assign head_ext  = {{OUT_NUM_BITS{1'b0}}, num_arr[0]};

   always_comb begin
      next_number_in = next_number_ff;
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      out_in         = out_ff;
      out_num_in     = out_num_ff;
      has_tasks_in   = has_tasks_ff;
      if (rsp_tvalid && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_tuser == REQ_ADD) begin
            next_number_in = next_number_ff + NUMBER_BITS'(1);
            status_in      = full ? STATUS_FULL : STATUS_DONE;
            out_in         = new_data;
            out_num_in     = stamp_ext[OUT_NUM_BITS-1:0];
            has_tasks_in   = 1'b1;
         end else if (vld[0]) begin
            status_in    = STATUS_DONE;
            out_in       = data_arr[0];
            out_num_in   = head_ext[OUT_NUM_BITS-1:0];
            has_tasks_in = vld[1];
         end else begin
            status_in    = STATUS_EMPTY;
            out_in       = '0;
            out_num_in   = '0;
            has_tasks_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_number_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         next_number_ff <= next_number_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      out_ff       <= out_in;
      out_num_ff   <= out_num_in;
      has_tasks_ff <= has_tasks_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {4'd0, has_tasks_ff, out_num_ff, out_ff.prio, out_ff.tag};

   // filled cells form an unbroken run from the head
   a_packed_chain: assert property (@(posedge clock) disable iff (reset)
      (vld & (vld + QUEUE_DEPTH'(1))) == '0)
      else $error("chain has a hole");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      vld[1] |-> (data_arr[0].prio >= data_arr[1].prio))
      else $error("head outranked by second cell");

   a_has_tasks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (has_tasks_ff == vld[0]))
      else $error("has_tasks disagrees with chain");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == REQ_ADD && full) |=> $stable(vld))
      else $error("dropped add changed the chain");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == REQ_ADD) |=>
         (next_number_ff == $past(next_number_ff) + NUMBER_BITS'(1)))
      else $error("task number did not advance");

endmodule

// ===== src/spq_cell.sv =====
module spq_cell
   import spq_pkg::*;
#(
   parameter int NUMBER_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  entry_type              new_data,
   input  logic [NUMBER_BITS-1:0] new_number,
   input  logic                   left_valid,
   input  entry_type              left_data,
   input  logic [NUMBER_BITS-1:0] left_number,
   input  logic                   left_ins,
   input  logic                   right_valid,
   input  entry_type              right_data,
   input  logic [NUMBER_BITS-1:0] right_number,
   output logic                   valid,
   output entry_type              data,
   output logic [NUMBER_BITS-1:0] number,
   output logic                   ins
);

   logic                   valid_ff;
   logic                   valid_in;
   entry_type              data_ff;
   entry_type              data_in;
   logic [NUMBER_BITS-1:0] number_ff;
   logic [NUMBER_BITS-1:0] number_in;

   // insert at or ahead of this cell when it is empty or holds a lower priority
   assign ins = !valid_ff || (new_data.prio > data_ff.prio);

   always_comb begin
      valid_in  = valid_ff;
      data_in   = data_ff;
      number_in = number_ff;
      priority if (cmd.pop) begin
         valid_in  = right_valid;
         data_in   = right_data;
         number_in = right_number;
      end else if (cmd.push && ins && left_ins) begin
         valid_in  = left_valid;
         data_in   = left_data;
         number_in = left_number;
      end else if (cmd.push && ins) begin
         valid_in  = 1'b1;
         data_in   = new_data;
         number_in = new_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      number_ff <= number_in;
   end

   assign valid  = valid_ff;
   assign data   = data_ff;
   assign number = number_ff;

endmodule

// ===== dv/tb_stable_priority_task_queue.sv =====
`timescale 1ns / 1ps

module tb_stable_priority_task_queue;
   import spq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int QUIET_START    = 1500;
   localparam int QUIET_STOP     = 2300;

   typedef struct packed {
      logic                 kind;
      logic [PRIO_BITS-1:0] prio;
      logic [TAG_BITS-1:0]  tag;
   } task_request_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [TAG_BITS-1:0]     tag;
      logic [PRIO_BITS-1:0]    prio;
      logic [OUT_NUM_BITS-1:0] number;
      logic                    has_tasks;
   } task_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        req_tuser  = REQ_ADD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   task_request_type pending_words[$];
   task_result_type  outcome_fifo[$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               stall_count = 0;

   logic                    held_valid [DEPTH];
   logic [PRIO_BITS-1:0]    held_prio  [DEPTH];
   logic [TAG_BITS-1:0]     held_tag   [DEPTH];
   logic [OUT_NUM_BITS-1:0] held_number[DEPTH];
   logic [OUT_NUM_BITS-1:0] stamp_counter;

   stable_priority_task_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic task_result_type serve_request(task_request_type rq);
      task_result_type         res;
      int                      pick;
      logic [OUT_NUM_BITS-1:0] age;
      logic [OUT_NUM_BITS-1:0] pick_age;
      res      = '0;
      pick     = -1;
      pick_age = '0;
      if (rq.kind == REQ_ADD) begin
         res.tag    = rq.tag;
         res.prio   = rq.prio;
         res.number = stamp_counter;
         stamp_counter = stamp_counter + 1;
         for (int i = 0; i < DEPTH; i++) begin
            if (!held_valid[i] && pick < 0) begin
               pick = i;
            end
         end
         if (pick >= 0) begin
            held_valid[pick]  = 1'b1;
            held_prio[pick]   = rq.prio;
            held_tag[pick]    = rq.tag;
            held_number[pick] = res.number;
            res.status        = STATUS_DONE;
         end else begin
            res.status = STATUS_FULL;
         end
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (held_valid[i]) begin
               age = stamp_counter - held_number[i];
               if (pick < 0 || held_prio[i] > held_prio[pick] ||
                   (held_prio[i] == held_prio[pick] && age > pick_age)) begin
                  pick     = i;
                  pick_age = age;
               end
            end
         end
         if (pick >= 0) begin
            held_valid[pick] = 1'b0;
            res.tag          = held_tag[pick];
            res.prio         = held_prio[pick];
            res.number       = held_number[pick];
            res.status       = STATUS_DONE;
         end else begin
            res.status = STATUS_EMPTY;
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (held_valid[i]) begin
            res.has_tasks = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic queue_word(logic kind, logic [PRIO_BITS-1:0] prio,
                             logic [TAG_BITS-1:0] tag);
      task_request_type rq;
      rq.kind = kind;
      rq.prio = prio;
      rq.tag  = tag;
      pending_words.push_back(rq);
   endtask

   function automatic logic quiet_window();
      return cycle_count >= QUIET_START && cycle_count < QUIET_STOP;
   endfunction

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() > 0 &&
             (quiet_window() || $urandom_range(99) >= 29)) begin
            task_request_type rq;
            rq = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, rq.tag, rq.prio};
            req_tuser  <= rq.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet_window() || $urandom_range(99) >= 29;
      end
   end

   // monitor
   always @(posedge clock) begin
      task_request_type rq;
      task_result_type  got;
      task_result_type  want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            held_valid[i] = 1'b0;
         end
         stamp_counter = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.kind = req_tuser;
            rq.prio = req_tdata[2:0];
            rq.tag  = req_tdata[18:3];
            outcome_fifo.push_back(serve_request(rq));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tuser;
            got.tag       = rsp_tdata[15:0];
            got.prio      = rsp_tdata[18:16];
            got.number    = rsp_tdata[50:19];
            got.has_tasks = rsp_tdata[51];
            if (outcome_fifo.size() == 0) begin
               $error("unexpected result word: status %0h tag %0h", got.status, got.tag);
               error_count++;
            end else begin
               want = outcome_fifo.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0h actual %0h", want.status, got.status);
                  error_count++;
               end
               if (got.tag !== want.tag) begin
                  $error("out_tag: expected %0h actual %0h", want.tag, got.tag);
                  error_count++;
               end
               if (got.prio !== want.prio) begin
                  $error("out_priority: expected %0h actual %0h", want.prio, got.prio);
                  error_count++;
               end
               if (got.number !== want.number) begin
                  $error("task_number: expected %0h actual %0h", want.number, got.number);
                  error_count++;
               end
               if (got.has_tasks !== want.has_tasks) begin
                  $error("has_tasks: expected %0h actual %0h",
                         want.has_tasks, got.has_tasks);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("tb_stable_priority_task_queue: FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      int add_pct;
      // pop on empty, extremes, tiebreak among equal priorities
      queue_word(REQ_POP, 3'd0, 16'h0000);
      queue_word(REQ_ADD, 3'd7, 16'hFFFF);
      queue_word(REQ_ADD, 3'd0, 16'h0000);
      queue_word(REQ_ADD, 3'd7, 16'h1234);
      queue_word(REQ_POP, 3'd7, 16'hFFFF);
      queue_word(REQ_POP, 3'd0, 16'h0000);
      queue_word(REQ_POP, 3'd0, 16'h0000);
      queue_word(REQ_POP, 3'd0, 16'h0000);
      // fill up, then overflow
      for (int i = 0; i < DEPTH; i++) begin
         queue_word(REQ_ADD, 3'(i % 3), 16'(16'hA500 + i));
      end
      queue_word(REQ_ADD, 3'd5, 16'h5A5A);
      queue_word(REQ_POP, 3'd0, 16'h0000);

      for (int n = 0; n < RANDOM_ITEMS; n += 40) begin
         case ($urandom_range(3))
            0:       add_pct = 20;
            1:       add_pct = 50;
            2:       add_pct = 80;
            default: add_pct = 95;
         endcase
         for (int k = 0; k < 40; k++) begin
            queue_word(($urandom_range(99) < add_pct) ? REQ_ADD : REQ_POP,
                       3'($urandom_range(7)), 16'($urandom));
         end
      end

      @(negedge clock);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || req_tvalid) @(posedge clock);
      while (outcome_fifo.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_stable_priority_task_queue: PASS");
      end else begin
         $display("tb_stable_priority_task_queue: FAIL");
      end
      $finish;
   end

endmodule
